// ----- src/dpts_pkg.sv -----
// ----------------------------------------------------------------------------
// dpts_pkg
// Shared types and constants for the dynamic priority tick scheduler: the
// process table entry, the result record, command codes and the sequencer
// states.
// ----------------------------------------------------------------------------
package dpts_pkg;

  localparam int unsigned DPTS_MAX_ENTRIES = 16;
  localparam int unsigned DPTS_TIME_BITS   = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0]  PRIO_MAX = 8'hFF;
  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] ran;
    logic [15:0] waited;
    logic        done;
  } entry_t;

  typedef struct packed {
    logic        load_rejected;
    logic        ran;
    logic [7:0]  run_pid;
    logic        finished;
    logic [15:0] finish_time;
    logic [15:0] wait_total;
    logic [15:0] turnaround;
    logic [15:0] tick_time;
    logic        all_done;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_SWEEP,
    ST_APPLY,
    ST_RESP
  } state_e;

endpackage

// ----- src/dynamic_priority_tick_scheduler.sv -----
// ----------------------------------------------------------------------------
// dynamic_priority_tick_scheduler
// Load beats append entries to a process table; tick beats pick the eligible
// entry with the smallest priority value (then smaller pid, then lower slot),
// run it for one unit and, unless it completes, age the others.
// ----------------------------------------------------------------------------
// Flow: a load beat passes through ST_LOAD and ST_RESP. A tick walks the table
// in ST_SCAN; it then responds idle, applies the run in ST_APPLY when its entry
// completes, or first ages the others in ST_SWEEP and then applies the run.
// Throughput: one beat at a time; input is ready again once the result is in
// the output register, later while the output waits. The single table read
// port, walked for the scan and the sweep, sets it.
// Reset: the table is empty and the clock reads 1; the table memory itself is
// not cleared, and only slots that have been loaded are ever read.
// ----------------------------------------------------------------------------
module dynamic_priority_tick_scheduler #(
  parameter int unsigned MAX_ENTRIES = dpts_pkg::DPTS_MAX_ENTRIES,
  parameter int unsigned TIME_BITS   = dpts_pkg::DPTS_TIME_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  proc_id_i,
  input  logic [15:0] arrive_at_i,
  input  logic [15:0] burst_len_i,
  input  logic [7:0]  start_priority_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        load_rejected_o,
  output logic        ran_o,
  output logic [7:0]  run_pid_o,
  output logic        finished_o,
  output logic [15:0] finish_time_o,
  output logic [15:0] wait_total_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] tick_time_o,
  output logic        all_done_o
);
  import dpts_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [CntW-1:0]      CntMax  = CntW'(MAX_ENTRIES);
  localparam logic [CntW-1:0]      CntOne  = CntW'(1);
  localparam logic [TIME_BITS-1:0] TimeMax = '1;
  localparam logic [TIME_BITS-1:0] TimeOne = TIME_BITS'(1);

  // Sequencer state.
  state_e state_q, state_d;

  // The accepted beat, held while the sequencer works on it.
  logic [7:0]  pid_q;
  logic [15:0] arr_q;
  logic [15:0] burst_q;
  logic [7:0]  prio_q;

  // Table bookkeeping: fill count, entries still pending, and the clock.
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      pending_q, pending_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // Scan and sweep address counter and the read pipeline tag.
  logic [CntW-1:0] issue_q, issue_d;
  logic            rvld_q, rvld_d;
  logic [IdxW-1:0] ridx_q, ridx_d;

  // Running selection: the best entry seen so far and its slot.
  logic            found_q, found_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  entry_t          best_q, best_d;

  // Result staging and output register.
  result_t res_q, res_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;

  // Table port.
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  entry_t          rdata;

  dpts_table #(
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // An entry read from the table is eligible when it is pending and has
  // already arrived. The selection compare orders by priority, then pid; a
  // strict compare keeps the lower slot on a full tie.
  logic              elig;
  logic              better;
  logic              issue_more;
  logic [15:0]       ran_inc;
  logic              fin;
  logic [TIME_BITS-1:0] next_time;
  logic [CmpW-1:0]   turn;
  logic [15:0]       tick_now;

  assign elig       = !rdata.done && (CmpW'(rdata.arrival) <= CmpW'(now_q));
  assign better     = !found_q || ({rdata.prio, rdata.pid} < {best_q.prio, best_q.pid});
  assign issue_more = (issue_q != count_q);
  assign ran_inc    = best_q.ran + 16'd1;
  assign fin        = (ran_inc >= best_q.burst);
  // The clock saturates at its top value; a completion time saturates too,
  // so the same increment serves both.
  assign next_time  = (now_q != TimeMax) ? (now_q + TimeOne) : now_q;
  assign turn       = CmpW'(next_time) - CmpW'(best_q.arrival);
  assign tick_now   = 16'(now_q);

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    count_d     = count_q;
    pending_d   = pending_q;
    now_d       = now_q;
    issue_d     = issue_q;
    rvld_d      = 1'b0;
    ridx_d      = ridx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = best_idx_q;
    mem_wdata   = best_q;
    mem_re      = 1'b0;
    mem_raddr   = issue_q[IdxW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          issue_d = '0;
          found_d = 1'b0;
          state_d = (cmd_i == CMD_TICK) ? ST_SCAN : ST_LOAD;
        end
      end

      ST_LOAD: begin
        res_d = '0;
        if (count_q == CntMax || burst_q == 16'd0) begin
          res_d.load_rejected = 1'b1;
          res_d.all_done      = (pending_q == '0);
        end else begin
          mem_we            = 1'b1;
          mem_waddr         = count_q[IdxW-1:0];
          mem_wdata.pid     = pid_q;
          mem_wdata.arrival = arr_q;
          mem_wdata.burst   = burst_q;
          mem_wdata.prio    = prio_q;
          mem_wdata.ran     = '0;
          mem_wdata.waited  = '0;
          mem_wdata.done    = 1'b0;
          count_d           = count_q + CntOne;
          pending_d         = pending_q + CntOne;
          res_d.all_done    = 1'b0;
        end
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        if (issue_more) begin
          mem_re  = 1'b1;
          rvld_d  = 1'b1;
          ridx_d  = issue_q[IdxW-1:0];
          issue_d = issue_q + CntOne;
        end
        if (rvld_q && elig && better) begin
          found_d    = 1'b1;
          best_idx_d = ridx_q;
          best_d     = rdata;
        end
        if (!issue_more && !rvld_q) begin
          if (!found_q) begin
            res_d           = '0;
            res_d.tick_time = tick_now;
            res_d.all_done  = (pending_q == '0);
            now_d           = next_time;
            state_d         = ST_RESP;
          end else if (fin) begin
            state_d = ST_APPLY;
          end else begin
            issue_d = '0;
            state_d = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        if (issue_more) begin
          mem_re  = 1'b1;
          rvld_d  = 1'b1;
          ridx_d  = issue_q[IdxW-1:0];
          issue_d = issue_q + CntOne;
        end
        // Every other eligible entry waits one more tick. The write goes to
        // the slot read last cycle, never the one being read now.
        if (rvld_q && ridx_q != best_idx_q && elig && rdata.waited != WAIT_MAX) begin
          mem_we           = 1'b1;
          mem_waddr        = ridx_q;
          mem_wdata        = rdata;
          mem_wdata.waited = rdata.waited + 16'd1;
        end
        if (!issue_more && !rvld_q) begin
          state_d = ST_APPLY;
        end
      end

      ST_APPLY: begin
        mem_we         = 1'b1;
        mem_waddr      = best_idx_q;
        mem_wdata      = best_q;
        mem_wdata.ran  = ran_inc;
        mem_wdata.done = fin;
        if (!fin && best_q.prio != PRIO_MAX) begin
          mem_wdata.prio = best_q.prio + 8'd1;
        end
        res_d             = '0;
        res_d.ran         = 1'b1;
        res_d.run_pid     = best_q.pid;
        res_d.finished    = fin;
        res_d.finish_time = fin ? 16'(next_time) : 16'd0;
        res_d.wait_total  = best_q.waited;
        res_d.turnaround  = fin ? turn[15:0] : 16'd0;
        res_d.tick_time   = tick_now;
        if (fin) begin
          pending_d      = pending_q - CntOne;
          res_d.all_done = (pending_q == CntOne);
        end else begin
          res_d.all_done = (pending_q == '0);
        end
        now_d   = next_time;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pending_q   <= '0;
      now_q       <= TimeOne;
      issue_q     <= '0;
      rvld_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pending_q   <= pending_d;
      now_q       <= now_d;
      issue_q     <= issue_d;
      rvld_q      <= rvld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pid_q   <= proc_id_i;
      arr_q   <= arrive_at_i;
      burst_q <= burst_len_i;
      prio_q  <= start_priority_i;
    end
    ridx_q     <= ridx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign load_rejected_o = out_q.load_rejected;
  assign ran_o           = out_q.ran;
  assign run_pid_o       = out_q.run_pid;
  assign finished_o      = out_q.finished;
  assign finish_time_o   = out_q.finish_time;
  assign wait_total_o    = out_q.wait_total;
  assign turnaround_o    = out_q.turnaround;
  assign tick_time_o     = out_q.tick_time;
  assign all_done_o      = out_q.all_done;

  // The pending count can never run ahead of the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pending_q <= count_q)
    else $error("pending entries exceed loaded entries");

  // The table never fills beyond its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("fill count beyond table depth");

  // The clock starts at one and only moves upward, so it is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) now_q != '0)
    else $error("clock reads zero");

  // A completion is only reported for a beat in which an entry ran.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && finished_o |-> ran_o)
    else $error("finished without a run");

  // Work on a load beat finishes in the cycle after it starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == ST_LOAD |=> state_q == ST_RESP)
    else $error("load did not reach the response stage");

endmodule

// ----- src/dpts_table.sv -----
// ----------------------------------------------------------------------------
// dpts_table
// Process table memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module dpts_table #(
  parameter int unsigned DEPTH = dpts_pkg::DPTS_MAX_ENTRIES,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IdxW-1:0]      waddr_i,
  input  dpts_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [IdxW-1:0]      raddr_i,
  output dpts_pkg::entry_t     rdata_o
);
  import dpts_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dynamic priority tick scheduler. A directed
// table of load and tick beats comes first. Three phases of random
// well-formed traffic follow, with noise mixed in. Every result beat is compared
// field by field with a behavioral prediction of the process table, or with the answer a directed row carries.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpts_pkg::*;

  localparam logic [15:0] TIME_TOP    = 16'hFFFF;
  localparam int unsigned PHASE_BEATS = 135;
  localparam int unsigned RX_HOLD     = 150;
  // The limit covers the slowest beat, the long receiver hold and random gaps
  // on both sides, taken several times over.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_TAIL  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [7:0]  proc_id_i;
  logic [15:0] arrive_at_i;
  logic [15:0] burst_len_i;
  logic [7:0]  start_priority_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        load_rejected_o;
  logic        ran_o;
  logic [7:0]  run_pid_o;
  logic        finished_o;
  logic [15:0] finish_time_o;
  logic [15:0] wait_total_o;
  logic [15:0] turnaround_o;
  logic [15:0] tick_time_o;
  logic        all_done_o;

  dynamic_priority_tick_scheduler i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .proc_id_i        (proc_id_i),
    .arrive_at_i      (arrive_at_i),
    .burst_len_i      (burst_len_i),
    .start_priority_i (start_priority_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .load_rejected_o  (load_rejected_o),
    .ran_o            (ran_o),
    .run_pid_o        (run_pid_o),
    .finished_o       (finished_o),
    .finish_time_o    (finish_time_o),
    .wait_total_o     (wait_total_o),
    .turnaround_o     (turnaround_o),
    .tick_time_o      (tick_time_o),
    .all_done_o       (all_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction: a private copy of the process table and of the clock.
  // --------------------------------------------------------------------------
  entry_t      tbl [DPTS_MAX_ENTRIES];
  int unsigned tbl_count = 0;
  logic [15:0] clk_now   = 16'd1;
  result_t     pending_results [$];

  function automatic result_t make_result(logic rej, logic ran, logic [7:0] pid,
                                          logic fin, logic [15:0] ftime,
                                          logic [15:0] wt, logic [15:0] turn,
                                          logic [15:0] tick, logic alld);
    result_t r;
    r.load_rejected = rej;
    r.ran           = ran;
    r.run_pid       = pid;
    r.finished      = fin;
    r.finish_time   = ftime;
    r.wait_total    = wt;
    r.turnaround    = turn;
    r.tick_time     = tick;
    r.all_done      = alld;
    return r;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf({"rej=%0b ran=%0b pid=%0d fin=%0b ftime=%0d ",
                      "wait=%0d turn=%0d tick=%0d all=%0b"},
                     r.load_rejected, r.ran, r.run_pid, r.finished, r.finish_time,
                     r.wait_total, r.turnaround, r.tick_time, r.all_done);
  endfunction

  // An empty table counts as finished.
  function automatic logic table_finished();
    for (int unsigned i = 0; i < tbl_count; i++)
      if (!tbl[i].done) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic runnable(int unsigned idx);
    return !tbl[idx].done && tbl[idx].arrival <= clk_now;
  endfunction

  // Apply one beat to the table and return the result that it should produce.
  function automatic result_t sched_step(logic cmd, logic [7:0] pid, logic [15:0] arr,
                                         logic [15:0] burst, logic [7:0] prio);
    result_t     r;
    int unsigned best;
    bit          found;
    logic [15:0] fin;
    r     = '0;
    best  = 0;
    found = 1'b0;
    if (cmd == CMD_LOAD) begin
      if (tbl_count >= DPTS_MAX_ENTRIES || burst == 16'd0) begin
        r.load_rejected = 1'b1;
      end else begin
        tbl[tbl_count].pid     = pid;
        tbl[tbl_count].arrival = arr;
        tbl[tbl_count].burst   = burst;
        tbl[tbl_count].prio    = prio;
        tbl[tbl_count].ran     = '0;
        tbl[tbl_count].waited  = '0;
        tbl[tbl_count].done    = 1'b0;
        tbl_count++;
      end
      r.all_done = table_finished();
      return r;
    end
    // Smallest priority value wins, then the smaller pid. The strict compare
    // leaves a full tie with the lower slot.
    for (int unsigned i = 0; i < tbl_count; i++) begin
      if (runnable(i) && (!found || tbl[i].prio < tbl[best].prio ||
          (tbl[i].prio == tbl[best].prio && tbl[i].pid < tbl[best].pid))) begin
        best  = i;
        found = 1'b1;
      end
    end
    r.tick_time = clk_now;
    if (found) begin
      r.ran     = 1'b1;
      r.run_pid = tbl[best].pid;
      tbl[best].ran = tbl[best].ran + 16'd1;
      if (tbl[best].ran >= tbl[best].burst) begin
        fin = (clk_now != TIME_TOP) ? clk_now + 16'd1 : TIME_TOP;
        tbl[best].done = 1'b1;
        r.finished     = 1'b1;
        r.finish_time  = fin;
        r.turnaround   = fin - tbl[best].arrival;
      end else begin
        if (tbl[best].prio != PRIO_MAX) tbl[best].prio = tbl[best].prio + 8'd1;
        for (int unsigned i = 0; i < tbl_count; i++)
          if (i != best && runnable(i) && tbl[i].waited != WAIT_MAX)
            tbl[i].waited = tbl[i].waited + 16'd1;
      end
      r.wait_total = tbl[best].waited;
    end
    if (clk_now != TIME_TOP) clk_now = clk_now + 16'd1;
    r.all_done = table_finished();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge it predicts every accepted input beat and
  // checks every accepted result beat against the oldest prediction. It also
  // runs the watchdog on cycles in which neither channel moves a beat.
  // --------------------------------------------------------------------------
  bit          typed_pending = 1'b0;
  result_t     typed_want    = '0;
  int unsigned bad_results   = 0;
  int unsigned results_seen  = 0;
  int unsigned loads_taken   = 0;
  int unsigned loads_refused = 0;
  int unsigned ticks_idle    = 0;
  int unsigned ticks_run     = 0;
  int unsigned completions   = 0;
  int unsigned quiet_cycles  = 0;

  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      moved = 1'b1;
      want = sched_step(cmd_i, proc_id_i, arrive_at_i, burst_len_i, start_priority_i);
      if (cmd_i == CMD_LOAD) begin
        if (want.load_rejected) loads_refused++;
        else loads_taken++;
      end else if (!want.ran) begin
        ticks_idle++;
      end else begin
        ticks_run++;
        if (want.finished) completions++;
      end
      // A directed row with its answer written out replaces the prediction.
      // The table still advances through sched_step above.
      pending_results.insert(pending_results.size(), typed_pending ? typed_want : want);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      moved = 1'b1;
      results_seen++;
      got = make_result(load_rejected_o, ran_o, run_pid_o, finished_o, finish_time_o,
                        wait_total_o, turnaround_o, tick_time_o, all_done_o);
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d arrived with nothing pending: %s", results_seen,
                   describe(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result %0d differs: expected %s, got %s", results_seen,
                     describe(want), describe(got));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results still pending.",
               QUIET_LIMIT, pending_results.size());
      $display("dynamic_priority_tick_scheduler: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It drops ready at random by rx_idle_pct. When the main thread
  // bumps hold_reqs, it also holds ready low while its own RX_HOLD countdown
  // runs, so the scheduler backs up and stalls its input.
  // --------------------------------------------------------------------------
  int unsigned rx_idle_pct = 67;
  int unsigned tx_idle_pct = 12;
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  always @(negedge clk_i) begin
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left   = RX_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender. It is called at a falling edge and returns at the falling edge
  // after the beat was taken. Valid is lowered only during a gap or a pause,
  // never in the same step in which it is raised.
  // --------------------------------------------------------------------------
  task automatic offer(input logic cmd, input logic [7:0] pid, input logic [15:0] arr,
                       input logic [15:0] burst, input logic [7:0] prio,
                       input bit typed = 1'b0, input result_t want = '0);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    cmd_i            = cmd;
    proc_id_i        = pid;
    arrive_at_i      = arr;
    burst_len_i      = burst;
    start_priority_i = prio;
    typed_pending    = typed;
    typed_want       = want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic offer_tick();
    offer(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Lower valid and hold back until every result has come back.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Directed stimulus. Rows with an answer written out carry it. All other
  // rows are checked against the prediction.
  // --------------------------------------------------------------------------
  typedef struct {
    logic        cmd;
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
    bit          typed;
    result_t     want;
  } row_t;

  row_t plan [$];

  function automatic void add_row(logic cmd, logic [7:0] pid, logic [15:0] arr,
                                  logic [15:0] burst, logic [7:0] prio,
                                  bit typed = 1'b0, result_t want = '0);
    row_t r;
    r.cmd   = cmd;
    r.pid   = pid;
    r.arr   = arr;
    r.burst = burst;
    r.prio  = prio;
    r.typed = typed;
    r.want  = want;
    plan.insert(plan.size(), r);
  endfunction

  int unsigned tx_plan [3] = '{12, 67, 0};
  int unsigned rx_plan [3] = '{67, 12, 0};

  initial begin : main
    int unsigned slots_left;
    int unsigned hold_at;
    int unsigned pause_at;
    int unsigned pick;
    int unsigned arr_wide;
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] arr;
    logic [15:0] burst;

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = CMD_LOAD;
    proc_id_i        = '0;
    arrive_at_i      = '0;
    burst_len_i      = '0;
    start_priority_i = '0;

    // A tick on the empty table idles at time 1 and reports the table finished.
    add_row(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1,
            make_result(1'b0, 1'b0, 8'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1));
    // A zero burst is refused, and the table stays empty.
    add_row(CMD_LOAD, 8'hAA, 16'h5555, 16'h0000, 8'h55, 1'b1,
            make_result(1'b1, 1'b0, 8'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    // Four accepted loads leave entries pending, so every field reads zero. The
    // first one arrives in the future. The next two share pid and priority, so
    // the lower slot must win their tie. The last one starts at the priority
    // ceiling and must stay there while it runs.
    add_row(CMD_LOAD, 8'h10, 16'd3, 16'd2, 8'd3, 1'b1, '0);
    add_row(CMD_LOAD, 8'h05, 16'd0, 16'd1, 8'd3, 1'b1, '0);
    add_row(CMD_LOAD, 8'h05, 16'd0, 16'd1, 8'd3, 1'b1, '0);
    add_row(CMD_LOAD, 8'hFF, 16'd0, 16'd3, 8'hFF, 1'b1, '0);
    // Run the table dry and add one idle tick. The payload of a tick is
    // ignored, so it carries extreme values here.
    for (int i = 0; i < 8; i++)
      add_row(CMD_TICK, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 16'hFFFF : 16'h0000,
              (i % 2) ? 16'h0000 : 16'hFFFF, (i % 2) ? 8'h00 : 8'hFF);
    // This entry arrives at the last clock value, which the run never reaches,
    // so it holds a slot and stays pending from here on.
    add_row(CMD_LOAD, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1, '0);
    add_row(CMD_TICK, 8'h5A, 16'hA5A5, 16'h5A5A, 8'hA5);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i])
      offer(plan[i].cmd, plan[i].pid, plan[i].arr, plan[i].burst, plan[i].prio,
            plan[i].typed, plan[i].want);

    // Random phases. Most beats are ticks. Loads arrive near the current time
    // and are spread out, so that the table fills up over the run. A few
    // malformed loads are mixed in: zero bursts, and loads once the table is
    // full. Over the three phases more loads are tried than the table can take.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_plan[ph];
      rx_idle_pct = rx_plan[ph];
      slots_left  = (ph == 2) ? 5 : 4;
      hold_at     = $urandom_range(10, 60);
      pause_at    = $urandom_range(70, 120);
      for (int unsigned k = 0; k < PHASE_BEATS; k++) begin
        if (k == hold_at) hold_reqs++;
        if (k == pause_at) wait_drained();
        pick = $urandom_range(99);
        // Small pid and priority ranges make ties and duplicates common.
        pid  = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        prio = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        if (pick < 4) begin
          burst = (tbl_count >= DPTS_MAX_ENTRIES) ? 16'($urandom_range(1, 65535)) : 16'd0;
          offer(CMD_LOAD, pid, 16'($urandom_range(65535)), burst, prio);
        end else if (slots_left != 0 && pick < 9) begin
          if ($urandom_range(9) == 0) begin
            arr = 16'($urandom_range(65535));
          end else begin
            arr_wide = clk_now + $urandom_range(8);
            arr      = (arr_wide > TIME_TOP) ? TIME_TOP : 16'(arr_wide);
          end
          pick = $urandom_range(19);
          if (pick < 15)      burst = 16'($urandom_range(1, 24));
          else if (pick < 19) burst = 16'($urandom_range(25, 300));
          else                burst = 16'($urandom_range(1, 65535));
          offer(CMD_LOAD, pid, arr, burst, prio);
          slots_left--;
        end else begin
          offer_tick();
        end
      end
    end

    wait_drained();
    // Wait a little longer than the slowest tick over a full table, so that a
    // stray extra result is caught.
    repeat (DRAIN_TAIL) @(negedge clk_i);

    $display("Covered %0d loads (%0d refused, %0d entries in the table) and %0d ticks",
             loads_taken + loads_refused, loads_refused, tbl_count,
             ticks_idle + ticks_run);
    $display("(%0d idle, %0d completions); the clock reached %0d; %0d of %0d results wrong.",
             ticks_idle, completions, clk_now, bad_results, results_seen);
    if (bad_results == 0) begin
      $display("dynamic_priority_tick_scheduler: match");
    end else begin
      $display("dynamic_priority_tick_scheduler: mismatch");
    end
    $finish;
  end

endmodule
